### rtl/hufd_pkg.sv
// Shared types and codes for the Huffman tree load and decode block.
// Used by the top level and its port checker; depends on nothing.
`default_nettype none

package hufd_pkg;

   localparam int SYMBOL_WIDTH = 8;
   localparam int EVENT_WIDTH  = 2;
   localparam int CFG_WIDTH    = 4;

   localparam logic [EVENT_WIDTH-1:0] EV_SYMBOL = 2'd0;
   localparam logic [EVENT_WIDTH-1:0] EV_LOADED = 2'd1;
   localparam logic [EVENT_WIDTH-1:0] EV_ERROR  = 2'd2;

   typedef struct packed {
      logic [EVENT_WIDTH-1:0]  event_res;
      logic [SYMBOL_WIDTH-1:0] symbol;
   } rsp_type;

endpackage

`default_nettype wire

### rtl/huffman_tree_load_and_decode.sv
// Huffman tree loader and bit-serial decoder, top level.
// Depends on hufd_pkg for result codes and the result type.
// Holds the node and parse-stack memories.
`default_nettype none

// Each request carries one stream bit. While loading, bits form a preorder tree header
// (1 = inner node, 0 = leaf followed by its symbol, csr_wr_data bits wide, MSB first);
// the request that completes the tree returns event 1, an overflow returns event 2 and
// then nothing more until a request with restart set. Once loaded, each bit walks one
// step (0 left, 1 right) and a leaf returns its symbol with event 0. The block takes no
// new request until it is done with the last: the walk step reads the next node from a
// synchronous node memory, and a stack pop during loading reads the stack the same way.
// A result waits in a two-entry output buffer; requests stall while one is in progress
// or both entries are full. No clearing pass follows reset: tables are written before use.
module huffman_tree_load_and_decode #(
   parameter int MAX_SYMBOL_BITS = 8,
   parameter int NODE_SLOTS      = 511
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_tvalid,
   output logic                                  req_tready,
   input  wire  [7:0]                            req_tdata,    // [0] bit_req, rest zero
   input  wire                                   req_tuser,    // [0] restart
   output logic                                  rsp_tvalid,
   input  wire                                   rsp_tready,
   output logic [hufd_pkg::SYMBOL_WIDTH-1:0]     rsp_tdata,    // [7:0] symbol
   output logic [hufd_pkg::EVENT_WIDTH-1:0]      rsp_tuser,    // [1:0] event_res
   input  wire                                   csr_wr_en,
   input  wire  [hufd_pkg::CFG_WIDTH-1:0]        csr_wr_data   // [3:0] symbol_bits
);

   localparam int STACK_DEPTH = (NODE_SLOTS + 1) / 2;
   localparam int NODE_W      = $clog2(NODE_SLOTS);
   localparam int COUNT_W     = $clog2(NODE_SLOTS + 1);
   localparam int STACK_W     = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int LEVEL_W     = $clog2(STACK_DEPTH + 1);
   localparam int SYM_W       = hufd_pkg::SYMBOL_WIDTH;
   localparam int CFG_W       = hufd_pkg::CFG_WIDTH;
   localparam int NODE_WORD_W = 1 + NODE_W + SYM_W;

   localparam logic [1:0] PH_LOAD   = 2'd0;
   localparam logic [1:0] PH_DECODE = 2'd1;
   localparam logic [1:0] PH_ERROR  = 2'd2;

   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_POP  = 2'd1;
   localparam logic [1:0] KIND_WALK = 2'd2;
   localparam logic [1:0] KIND_EMIT = 2'd3;

   // memories
   logic [NODE_WORD_W-1:0] node_mem  [0:NODE_SLOTS-1];   // {inner, right, symbol}
   logic [NODE_W-1:0]      stack_mem [0:STACK_DEPTH-1];

   logic [NODE_WORD_W-1:0] node_q_ff;
   logic [NODE_W-1:0]      stack_q_ff;

   logic                   node_we, stack_we, node_re, stack_re;
   logic [NODE_W-1:0]      node_waddr, node_raddr, stack_wdata;
   logic [NODE_WORD_W-1:0] node_wdata;
   logic [STACK_W-1:0]     stack_waddr, stack_raddr;

   // control and walk state
   logic [1:0]          phase_ff, phase_in;
   logic [LEVEL_W-1:0]  level_ff, level_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [NODE_W-1:0]   cur_ff, cur_in;
   logic [NODE_W-1:0]   cur_right_ff, cur_right_in;
   logic [3:0]          left_ff, left_in;
   logic [SYM_W-1:0]    shift_ff, shift_in;
   logic                root_inner_ff, root_inner_in;
   logic [NODE_W-1:0]   root_right_ff, root_right_in;
   logic [SYM_W-1:0]    root_sym_ff, root_sym_in;
   logic [CFG_W-1:0]    sym_bits_ff;

   logic                busy_ff, busy_in;
   logic [1:0]          kind_ff, kind_in;
   logic [NODE_W-1:0]   walk_addr_ff, walk_addr_in;
   hufd_pkg::rsp_type   res_ff, res_in;

   // output buffer
   logic                out_v_ff, out_v_in, skid_v_ff, skid_v_in;
   hufd_pkg::rsp_type   out_ff, out_in, skid_ff, skid_in;
   logic                push_v;
   hufd_pkg::rsp_type   push_d;

   logic                req_acc, req_bit, out_pop;
   logic [1:0]          eff_phase;
   logic [LEVEL_W-1:0]  eff_level, level_m1;
   logic [COUNT_W-1:0]  eff_count, count_m1;
   logic [NODE_W-1:0]   eff_cur;
   logic [3:0]          eff_left, sym_width;

   assign req_bit    = req_tdata[0];
   assign req_acc    = req_tvalid & req_tready;
   assign req_tready = !busy_ff && !skid_v_ff;
   assign out_pop    = out_v_ff & rsp_tready;

   assign eff_phase = req_tuser ? PH_LOAD : phase_ff;
   assign eff_level = req_tuser ? '0 : level_ff;
   assign eff_count = req_tuser ? '0 : count_ff;
   assign eff_cur   = req_tuser ? '0 : cur_ff;
   assign eff_left  = req_tuser ? '0 : left_ff;
   assign level_m1  = eff_level - LEVEL_W'(1);
   assign count_m1  = eff_count - COUNT_W'(1);

   assign sym_width = (sym_bits_ff == '0) ? 4'd1 :
                      (sym_bits_ff > 4'(MAX_SYMBOL_BITS)) ? 4'(MAX_SYMBOL_BITS) :
                      sym_bits_ff;

   always_comb begin
      phase_in      = phase_ff;
      level_in      = level_ff;
      count_in      = count_ff;
      cur_in        = cur_ff;
      cur_right_in  = cur_right_ff;
      left_in       = left_ff;
      shift_in      = shift_ff;
      root_inner_in = root_inner_ff;
      root_right_in = root_right_ff;
      root_sym_in   = root_sym_ff;
      busy_in       = 1'b0;
      kind_in       = KIND_NONE;
      walk_addr_in  = walk_addr_ff;
      res_in        = res_ff;
      node_we       = 1'b0;
      node_waddr    = '0;
      node_wdata    = '0;
      node_re       = 1'b0;
      node_raddr    = '0;
      stack_we      = 1'b0;
      stack_waddr   = '0;
      stack_wdata   = '0;
      stack_re      = 1'b0;
      stack_raddr   = '0;
      push_v        = 1'b0;
      push_d        = res_ff;

      if (busy_ff) begin
         unique case (kind_ff)
            KIND_POP: begin
               // the next node allocated is the right child of the popped node
               cur_in     = stack_q_ff;
               node_we    = 1'b1;
               node_waddr = stack_q_ff;
               node_wdata = {1'b1, count_ff[NODE_W-1:0], {SYM_W{1'b0}}};
               if (stack_q_ff == '0) begin
                  root_right_in = count_ff[NODE_W-1:0];
               end
            end
            KIND_WALK: begin
               if (node_q_ff[NODE_WORD_W-1]) begin
                  cur_in       = walk_addr_ff;
                  cur_right_in = node_q_ff[SYM_W +: NODE_W];
               end else begin
                  cur_in           = '0;
                  cur_right_in     = root_right_ff;
                  push_v           = 1'b1;
                  push_d.event_res = hufd_pkg::EV_SYMBOL;
                  push_d.symbol    = node_q_ff[SYM_W-1:0];
               end
            end
            KIND_EMIT: begin
               push_v = 1'b1;
            end
            default: ;
         endcase
      end else if (req_acc) begin
         busy_in  = 1'b1;
         phase_in = eff_phase;
         level_in = eff_level;
         count_in = eff_count;
         cur_in   = eff_cur;
         left_in  = eff_left;
         unique case (eff_phase)
            PH_LOAD: begin
               if (eff_left != '0) begin
                  // shift in one symbol bit
                  shift_in = {shift_ff[SYM_W-2:0], req_bit};
                  left_in  = eff_left - 4'd1;
                  if (eff_left == 4'd1) begin
                     node_we    = 1'b1;
                     node_waddr = count_m1[NODE_W-1:0];
                     node_wdata = {1'b0, {NODE_W{1'b0}}, shift_in};
                     if (count_m1 == '0) begin
                        root_sym_in = shift_in;
                     end
                     if (eff_level == '0) begin
                        phase_in         = PH_DECODE;
                        cur_in           = '0;
                        cur_right_in     = root_right_ff;
                        kind_in          = KIND_EMIT;
                        res_in.event_res = hufd_pkg::EV_LOADED;
                        res_in.symbol    = '0;
                     end else begin
                        level_in    = level_m1;
                        stack_re    = 1'b1;
                        stack_raddr = level_m1[STACK_W-1:0];
                        kind_in     = KIND_POP;
                     end
                  end
               end else if (eff_count >= COUNT_W'(NODE_SLOTS)) begin
                  phase_in         = PH_ERROR;
                  kind_in          = KIND_EMIT;
                  res_in.event_res = hufd_pkg::EV_ERROR;
                  res_in.symbol    = '0;
               end else begin
                  // allocate node
                  node_we    = 1'b1;
                  node_waddr = eff_count[NODE_W-1:0];
                  node_wdata = {req_bit, {NODE_W{1'b0}}, {SYM_W{1'b0}}};
                  if (eff_count == '0) begin
                     root_inner_in = req_bit;
                  end
                  count_in      = eff_count + COUNT_W'(1);
                  if (req_bit) begin
                     if (eff_level >= LEVEL_W'(STACK_DEPTH)) begin
                        phase_in         = PH_ERROR;
                        kind_in          = KIND_EMIT;
                        res_in.event_res = hufd_pkg::EV_ERROR;
                        res_in.symbol    = '0;
                     end else begin
                        stack_we    = 1'b1;
                        stack_waddr = eff_level[STACK_W-1:0];
                        stack_wdata = eff_count[NODE_W-1:0];
                        level_in    = eff_level + LEVEL_W'(1);
                     end
                  end else begin
                     left_in  = sym_width;
                     shift_in = '0;
                  end
               end
            end
            PH_DECODE: begin
               if (!root_inner_ff) begin
                  kind_in          = KIND_EMIT;
                  res_in.event_res = hufd_pkg::EV_SYMBOL;
                  res_in.symbol    = root_sym_ff;
               end else begin
                  node_re      = 1'b1;
                  node_raddr   = req_bit ? cur_right_ff : cur_ff + NODE_W'(1);
                  walk_addr_in = node_raddr;
                  kind_in      = KIND_WALK;
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      out_v_in  = out_v_ff;
      out_in    = out_ff;
      skid_v_in = skid_v_ff;
      skid_in   = skid_ff;
      if (out_pop) begin
         if (skid_v_ff) begin
            out_in    = skid_ff;
            skid_v_in = 1'b0;
         end else begin
            out_v_in = 1'b0;
         end
      end
      if (push_v) begin
         if (!out_v_in) begin
            out_v_in = 1'b1;
            out_in   = push_d;
         end else begin
            skid_v_in = 1'b1;
            skid_in   = push_d;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (node_we) begin
         node_mem[node_waddr] <= node_wdata;
      end
      if (node_re) begin
         node_q_ff <= node_mem[node_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_mem[stack_waddr] <= stack_wdata;
      end
      if (stack_re) begin
         stack_q_ff <= stack_mem[stack_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_LOAD;
         level_ff      <= '0;
         count_ff      <= '0;
         cur_ff        <= '0;
         left_ff       <= '0;
         root_inner_ff <= 1'b0;
         sym_bits_ff   <= CFG_W'(8);
         busy_ff       <= 1'b0;
         kind_ff       <= KIND_NONE;
         out_v_ff      <= 1'b0;
         skid_v_ff     <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         level_ff      <= level_in;
         count_ff      <= count_in;
         cur_ff        <= cur_in;
         left_ff       <= left_in;
         root_inner_ff <= root_inner_in;
         if (csr_wr_en) begin
            sym_bits_ff <= csr_wr_data;
         end
         busy_ff       <= busy_in;
         kind_ff       <= kind_in;
         out_v_ff      <= out_v_in;
         skid_v_ff     <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_right_ff  <= cur_right_in;
      shift_ff      <= shift_in;
      root_right_ff <= root_right_in;
      root_sym_ff   <= root_sym_in;
      walk_addr_ff  <= walk_addr_in;
      res_ff        <= res_in;
      out_ff        <= out_in;
      skid_ff       <= skid_in;
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_ff.symbol;
   assign rsp_tuser  = out_ff.event_res;

endmodule

`default_nettype wire

### rtl/hufd_checker.sv
// Port-level checker for the Huffman tree load and decode block, bound to the top level.
// Depends on hufd_pkg for result codes.
`default_nettype none

module hufd_checker (
   input wire                                clock,
   input wire                                reset,
   input wire                                req_tvalid,
   input wire                                req_tready,
   input wire                                rsp_tvalid,
   input wire                                rsp_tready,
   input wire [hufd_pkg::SYMBOL_WIDTH-1:0]   rsp_tdata,
   input wire [hufd_pkg::EVENT_WIDTH-1:0]    rsp_tuser
);

   // drop any result after reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_event_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == hufd_pkg::EV_SYMBOL || rsp_tuser == hufd_pkg::EV_LOADED ||
                      rsp_tuser == hufd_pkg::EV_ERROR))
      else $error("undefined event code");

   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != hufd_pkg::EV_SYMBOL) |-> rsp_tdata == '0)
      else $error("status result carries a nonzero symbol");

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled result changed");

   a_two_cycle: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken in back-to-back cycles");

endmodule

bind huffman_tree_load_and_decode hufd_checker u_hufd_checker (.*);

`default_nettype wire
